// ===== rtl/banked_memory_io_decoder_assert.svh =====
// assertion macros for the decoder module
// each macro expects clk and rst_n in the using module
`ifndef BANKED_MEMORY_IO_DECODER_ASSERT_SVH
`define BANKED_MEMORY_IO_DECODER_ASSERT_SVH

// property that must hold at every clock edge outside reset
`define BMIO_CHECK(label, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("bmio check failed");

// same-cycle implication
`define BMIO_IMPLY(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bmio implication failed");

// next-cycle implication
`define BMIO_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bmio next-cycle check failed");

`endif

// ===== rtl/bmio_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmio_pkg
// shared constants, codes and result type of the banked memory i/o decoder
// ----------------------------------------------------------------------------
package bmio_pkg;

    localparam int BANK_COUNT   = 128;
    localparam int BANK_BYTES   = 8192;
    localparam int WINDOW_COUNT = 8;

    localparam int BANK_W   = $clog2(BANK_COUNT);
    localparam int OFFS_W   = $clog2(BANK_BYTES);
    localparam int WIN_W    = $clog2(WINDOW_COUNT);
    localparam int MEM_AW   = BANK_W + OFFS_W;
    localparam int MAP_W    = 7;
    localparam int IOOFF_W  = 9;
    localparam int SEEK_W   = 25;

    localparam logic [1:0] OP_READ  = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_TICK  = 2'd2;

    localparam logic [15:0] IO_LOW  = 16'hFE00;
    localparam logic [15:0] IO_HIGH = 16'hFFF0;

    localparam logic [IOOFF_W-1:0] IO_BANK_TOP  = 9'h008;
    localparam logic [IOOFF_W-1:0] IO_TIMER     = 9'h010;
    localparam logic [IOOFF_W-1:0] IO_CON_DATA  = 9'h020;
    localparam logic [IOOFF_W-1:0] IO_CON_STAT  = 9'h021;
    localparam logic [IOOFF_W-1:0] IO_DISK_SEL  = 9'h030;
    localparam logic [IOOFF_W-1:0] IO_BLK_HI    = 9'h031;
    localparam logic [IOOFF_W-1:0] IO_BLK_LO    = 9'h032;
    localparam logic [IOOFF_W-1:0] IO_SEEK      = 9'h033;
    localparam logic [IOOFF_W-1:0] IO_DISK_DATA = 9'h034;
    localparam logic [IOOFF_W-1:0] IO_DISK_STAT = 9'h035;
    localparam logic [IOOFF_W-1:0] IO_HALT      = 9'h040;

    localparam logic [7:0] HALT_CODE      = 8'hA5;
    localparam logic [7:0] UNMAPPED_BYTE  = 8'hFF;
    localparam logic [1:0] DSTAT_OK       = 2'h0;
    localparam logic [1:0] DSTAT_FAILED   = 2'h1;
    localparam logic [1:0] DSTAT_NO_DISK  = 2'h2;

    typedef struct packed {
        logic [7:0]        rdata;
        logic              use_mem;
        logic              irq;
        logic              rx_take;
        logic              tx_valid;
        logic [7:0]        tx_byte;
        logic              disk_read_take;
        logic              disk_write_valid;
        logic [7:0]        disk_out_byte;
        logic              seek_valid;
        logic [SEEK_W-1:0] seek_offset;
        logic              halt;
    } res_t;

endpackage

// ===== rtl/bmio_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmio_ram
// single-port synchronous ram with registered read
// ----------------------------------------------------------------------------
module bmio_ram #(
    parameter int AW = 20,
    parameter int DW = 8
) (
    input  logic          clk,
    input  logic          we,
    input  logic          re,
    input  logic [AW-1:0] addr,
    input  logic [DW-1:0] wdata,
    output logic [DW-1:0] rdata
);

    logic [DW-1:0] mem [2**AW];
    logic [DW-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/bmio_regs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmio_regs
// bank map, i/o registers and address decode; updates state on each accepted request
// ----------------------------------------------------------------------------
module bmio_regs (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       accept,
    input  logic [1:0]                 op,
    input  logic [15:0]                addr,
    input  logic [7:0]                 wdata,
    input  logic [7:0]                 rx_byte,
    input  logic                       rx_ready,
    input  logic                       tx_ready,
    input  logic [7:0]                 disk_in_byte,
    input  logic                       seek_failed,
    output logic                       mem_we,
    output logic                       mem_re,
    output logic [bmio_pkg::MEM_AW-1:0] mem_addr,
    output bmio_pkg::res_t             res
);

    import bmio_pkg::*;

    logic [MAP_W-1:0] bank_map_reg [WINDOW_COUNT];
    logic [MAP_W-1:0] bank_map_next [WINDOW_COUNT];
    logic [7:0]       timer_count_reg, timer_count_next;
    logic [7:0]       disk_select_reg, disk_select_next;
    logic [15:0]      block_number_reg, block_number_next;
    logic [1:0]       disk_status_reg, disk_status_next;

    logic               is_io;
    logic [IOOFF_W-1:0] off;
    logic [WIN_W-1:0]   win;
    logic [WIN_W-1:0]   bank_idx;

    assign is_io    = (addr >= IO_LOW) && (addr <= IO_HIGH);
    assign off      = addr[IOOFF_W-1:0];
    assign win      = addr[15:16-WIN_W];
    assign bank_idx = off[WIN_W-1:0];
    assign mem_addr = {BANK_W'(bank_map_reg[win]), addr[OFFS_W-1:0]};
    assign mem_re   = accept && (op == OP_READ) && !is_io;
    assign mem_we   = accept && (op == OP_WRITE) && !is_io;

    always_comb
    begin
        bank_map_next     = bank_map_reg;
        timer_count_next  = timer_count_reg;
        disk_select_next  = disk_select_reg;
        block_number_next = block_number_reg;
        disk_status_next  = disk_status_reg;
        res               = '0;
        if (op == OP_READ)
        begin
            res.rdata = UNMAPPED_BYTE;
            if (!is_io)
            begin
                res.use_mem = 1'b1;
            end
            else if (off < IO_BANK_TOP)
            begin
                res.rdata = 8'(bank_map_reg[bank_idx]);
            end
            else if (off == IO_TIMER)
            begin
                res.rdata        = timer_count_reg;
                timer_count_next = '0;
            end
            else if (off == IO_CON_DATA)
            begin
                if (rx_ready)
                begin
                    res.rdata   = rx_byte;
                    res.rx_take = 1'b1;
                end
            end
            else if (off == IO_CON_STAT)
            begin
                res.rdata = {6'b0, tx_ready, rx_ready};
            end
            else if (off == IO_DISK_SEL)
            begin
                res.rdata = disk_select_reg;
            end
            else if (off == IO_BLK_HI)
            begin
                res.rdata = block_number_reg[15:8];
            end
            else if (off == IO_BLK_LO)
            begin
                res.rdata = block_number_reg[7:0];
            end
            else if (off == IO_DISK_DATA)
            begin
                res.rdata          = disk_in_byte;
                res.disk_read_take = 1'b1;
            end
            else if (off == IO_DISK_STAT)
            begin
                res.rdata        = {6'b0, disk_status_reg};
                disk_status_next = '0;
            end
        end
        else if (op == OP_WRITE)
        begin
            if (!is_io)
            begin
                res.use_mem = 1'b0;
            end
            else if (off < IO_BANK_TOP)
            begin
                bank_map_next[bank_idx] = wdata[MAP_W-1:0];
            end
            else if (off == IO_CON_DATA)
            begin
                res.tx_valid = 1'b1;
                res.tx_byte  = wdata;
            end
            else if (off == IO_DISK_SEL)
            begin
                disk_select_next = wdata;
            end
            else if (off == IO_BLK_HI)
            begin
                block_number_next[15:8] = wdata;
            end
            else if (off == IO_BLK_LO)
            begin
                block_number_next[7:0] = wdata;
            end
            else if (off == IO_SEEK)
            begin
                if (disk_select_reg != 8'd0)
                begin
                    disk_status_next = DSTAT_NO_DISK;
                end
                else
                begin
                    res.seek_valid   = 1'b1;
                    res.seek_offset  = {block_number_reg, 9'b0};
                    disk_status_next = seek_failed ? DSTAT_FAILED : DSTAT_OK;
                end
            end
            else if (off == IO_DISK_DATA)
            begin
                res.disk_write_valid = 1'b1;
                res.disk_out_byte    = wdata;
            end
            else if ((off == IO_HALT) && (wdata == HALT_CODE))
            begin
                res.halt = 1'b1;
            end
        end
        else if (op == OP_TICK)
        begin
            timer_count_next = timer_count_reg + 8'd1;
        end
        res.irq = (timer_count_next != 8'd0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < WINDOW_COUNT; i++)
            begin
                bank_map_reg[i] <= MAP_W'(i);
            end
            timer_count_reg  <= '0;
            disk_select_reg  <= '0;
            block_number_reg <= '0;
            disk_status_reg  <= '0;
        end
        else if (accept)
        begin
            bank_map_reg     <= bank_map_next;
            timer_count_reg  <= timer_count_next;
            disk_select_reg  <= disk_select_next;
            block_number_reg <= block_number_next;
            disk_status_reg  <= disk_status_next;
        end
    end

endmodule

// ===== rtl/banked_memory_io_decoder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// banked_memory_io_decoder
// 8 KB window bank mapper into 1 MB ram with memory-mapped i/o registers
//
//   channel   handshake            payload
//   input     in_valid / in_ready  op addr wdata rx_byte rx_ready tx_ready
//                                  disk_in_byte seek_failed
//   output    out_valid/ out_ready rdata irq rx_take tx_valid tx_byte
//                                  disk_read_take disk_write_valid
//                                  disk_out_byte seek_valid seek_offset halt
//
// a request sits in the s1 register (its ram data in the ram read register),
// then in the output register; one request per cycle is sustained while
// out_ready stays high, set by the single ram port and its registered read
// register state changes on acceptance; the ram read data waits in its own
// register while the output is stalled
// reset clears bank map to identity and all i/o registers; ram is not cleared
// ----------------------------------------------------------------------------
module banked_memory_io_decoder (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  op,
    input  logic [15:0] addr,
    input  logic [7:0]  wdata,
    input  logic [7:0]  rx_byte,
    input  logic        rx_ready,
    input  logic        tx_ready,
    input  logic [7:0]  disk_in_byte,
    input  logic        seek_failed,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  rdata,
    output logic        irq,
    output logic        rx_take,
    output logic        tx_valid,
    output logic [7:0]  tx_byte,
    output logic        disk_read_take,
    output logic        disk_write_valid,
    output logic [7:0]  disk_out_byte,
    output logic        seek_valid,
    output logic [24:0] seek_offset,
    output logic        halt
);

    import bmio_pkg::*;
`include "banked_memory_io_decoder_assert.svh"

    logic              accept;
    logic              out_free;
    logic              mem_we;
    logic              mem_re;
    logic [MEM_AW-1:0] mem_addr;
    logic [7:0]        mem_rdata;
    res_t              req_res;
    res_t              s1_res_reg;
    logic              s1_valid_reg, s1_valid_next;
    res_t              out_res_reg, out_res_next;
    logic              out_valid_reg, out_valid_next;

    assign out_free = !out_valid_reg || out_ready;
    assign in_ready = !s1_valid_reg || out_free;
    assign accept   = in_valid && in_ready;

    bmio_regs u_regs (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .op           (op),
        .addr         (addr),
        .wdata        (wdata),
        .rx_byte      (rx_byte),
        .rx_ready     (rx_ready),
        .tx_ready     (tx_ready),
        .disk_in_byte (disk_in_byte),
        .seek_failed  (seek_failed),
        .mem_we       (mem_we),
        .mem_re       (mem_re),
        .mem_addr     (mem_addr),
        .res          (req_res)
    );

    bmio_ram #(
        .AW (MEM_AW),
        .DW (8)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .re    (mem_re),
        .addr  (mem_addr),
        .wdata (wdata),
        .rdata (mem_rdata)
    );

    always_comb
    begin
        s1_valid_next  = s1_valid_reg;
        out_valid_next = out_valid_reg;
        out_res_next   = out_res_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (s1_valid_reg && out_free)
        begin
            out_valid_next = 1'b1;
            out_res_next   = s1_res_reg;
            if (s1_res_reg.use_mem)
            begin
                out_res_next.rdata = mem_rdata;
            end
            s1_valid_next = 1'b0;
        end
        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_res_reg <= req_res;
        end
        out_res_reg <= out_res_next;
    end

    assign out_valid        = out_valid_reg;
    assign rdata            = out_res_reg.rdata;
    assign irq              = out_res_reg.irq;
    assign rx_take          = out_res_reg.rx_take;
    assign tx_valid         = out_res_reg.tx_valid;
    assign tx_byte          = out_res_reg.tx_byte;
    assign disk_read_take   = out_res_reg.disk_read_take;
    assign disk_write_valid = out_res_reg.disk_write_valid;
    assign disk_out_byte    = out_res_reg.disk_out_byte;
    assign seek_valid       = out_res_reg.seek_valid;
    assign seek_offset      = out_res_reg.seek_offset;
    assign halt             = out_res_reg.halt;

    `BMIO_NEXT(a_accept_fills_s1, accept, s1_valid_reg)
    `BMIO_NEXT(a_s1_moves_out, s1_valid_reg && out_free, out_valid_reg)
    `BMIO_NEXT(a_s1_holds, s1_valid_reg && !out_free, s1_valid_reg && $stable(s1_res_reg))
    `BMIO_IMPLY(a_one_side_effect, out_valid_reg,
        $onehot0({rx_take, tx_valid, disk_read_take, disk_write_valid, seek_valid, halt}))

endmodule
